@@ src/so3_exponential_map_defines.svh @@
// ----------------------------------------------------------------------------
// SO(3) exponential map: assertion macros
// Shared helpers that wrap concurrent assertions in a reset-aware form.
// ----------------------------------------------------------------------------
`ifndef SO3_EXPONENTIAL_MAP_DEFINES_SVH
`define SO3_EXPONENTIAL_MAP_DEFINES_SVH

// Property that must hold on every clock edge outside reset.
`define S3EM_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("s3em: check failed");

// Same-cycle implication.
`define S3EM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("s3em: implication failed");

// Next-cycle implication.
`define S3EM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("s3em: sequence failed");

`endif

@@ src/s3em_pkg.sv @@
// ----------------------------------------------------------------------------
// SO(3) exponential map: shared package
// Types, fixed-point constants and the sine series tables.
// ----------------------------------------------------------------------------
package s3em_pkg;

    localparam int THRESH_W = 29;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 29'd268;

    // Register address decode uses the word index bit.
    localparam logic REG_SMALL_THRESH = 1'b0;

    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [35:0] PI_Q32      = 36'h3_243F_6A89;
    localparam logic [35:0] HALF_PI_Q32 = 36'h1_921F_B544;
    localparam logic [35:0] TWO_PI_Q32  = 36'h6_487E_D511;

    // Horner steps are indexed 6 down to 0 for series terms k = 7 down to 1.
    localparam logic [2:0] SINE_FIRST = 3'd6;

    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [63:0]        sumsq;
    } q_item_t;

    typedef struct packed {
        logic              small_angle;
        logic [8:0][31:0]  r;
    } res_t;

    // Divisor 2k(2k+1) of the series term.
    function automatic logic [7:0] sine_div(input logic [2:0] kidx);
        logic [7:0] d;
        unique case (kidx)
            3'd0:    d = 8'd6;
            3'd1:    d = 8'd20;
            3'd2:    d = 8'd42;
            3'd3:    d = 8'd72;
            3'd4:    d = 8'd110;
            3'd5:    d = 8'd156;
            default: d = 8'd210;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor), used for the reciprocal multiply.
    function automatic logic [29:0] sine_recip(input logic [2:0] kidx);
        logic [29:0] m;
        unique case (kidx)
            3'd0:    m = 30'd715827882;
            3'd1:    m = 30'd214748364;
            3'd2:    m = 30'd102261126;
            3'd3:    m = 30'd59652323;
            3'd4:    m = 30'd39045157;
            3'd5:    m = 30'd27531841;
            default: m = 30'd20452225;
        endcase
        return m;
    endfunction

endpackage

@@ src/s3em_front.sv @@
// ----------------------------------------------------------------------------
// SO(3) exponential map: front stage
// Accepts rotation vectors and forms the squared magnitude for the queue.
// ----------------------------------------------------------------------------
module s3em_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [95:0]       in_data,     // rot_x, rot_y, rot_z from bit 0 up
    output logic              push_valid,
    input  logic              push_ready,
    output s3em_pkg::q_item_t push_item
);

    logic               stg_valid_reg;
    logic signed [31:0] vx_reg;
    logic signed [31:0] vy_reg;
    logic signed [31:0] vz_reg;
    logic signed [63:0] sqx_reg;
    logic signed [63:0] sqy_reg;
    logic signed [63:0] sqz_reg;
    logic               load;

    assign in_ready = !stg_valid_reg || push_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stg_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            vx_reg  <= $signed(in_data[31:0]);
            vy_reg  <= $signed(in_data[63:32]);
            vz_reg  <= $signed(in_data[95:64]);
            sqx_reg <= $signed(in_data[31:0]) * $signed(in_data[31:0]);
            sqy_reg <= $signed(in_data[63:32]) * $signed(in_data[63:32]);
            sqz_reg <= $signed(in_data[95:64]) * $signed(in_data[95:64]);
        end
    end

    // Each square is at most 2^62, so the sum of three fits in 64 unsigned bits.
    assign push_valid      = stg_valid_reg;
    assign push_item.vx    = vx_reg;
    assign push_item.vy    = vy_reg;
    assign push_item.vz    = vz_reg;
    assign push_item.sumsq = 64'(sqx_reg) + 64'(sqy_reg) + 64'(sqz_reg);

endmodule

@@ src/s3em_queue.sv @@
// ----------------------------------------------------------------------------
// SO(3) exponential map: item queue
// Small register FIFO between the front stage and the compute core.
// ----------------------------------------------------------------------------
module s3em_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  s3em_pkg::q_item_t push_item,
    output logic              pop_valid,
    input  logic              pop,
    output s3em_pkg::q_item_t pop_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    s3em_pkg::q_item_t mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ src/s3em_core.sv @@
// ----------------------------------------------------------------------------
// SO(3) exponential map: compute core
// Sequencer around one shared multiplier: square root, two sines, two
// divisions, products and the final matrix sums, with an output register.
// ----------------------------------------------------------------------------
`include "so3_exponential_map_defines.svh"

module s3em_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [s3em_pkg::THRESH_W-1:0] thresh,
    input  logic                         q_valid,
    output logic                         q_pop,
    input  s3em_pkg::q_item_t            q_item,
    output logic                         res_valid,
    input  logic                         res_ready,
    output s3em_pkg::res_t               res_out
);

    typedef enum logic [14:0] {
        ST_IDLE  = 15'b000000000000001,
        ST_SQRT  = 15'b000000000000010,
        ST_CLASS = 15'b000000000000100,
        ST_SRED1 = 15'b000000000001000,
        ST_SRED2 = 15'b000000000010000,
        ST_SX2   = 15'b000000000100000,
        ST_SMUL  = 15'b000000001000000,
        ST_SREC  = 15'b000000010000000,
        ST_SCOR  = 15'b000000100000000,
        ST_SFIN  = 15'b000001000000000,
        ST_DIV   = 15'b000010000000000,
        ST_PROD  = 15'b000100000000000,
        ST_BPRD  = 15'b001000000000000,
        ST_SUM   = 15'b010000000000000,
        ST_DONE  = 15'b100000000000000
    } state_t;

    localparam logic signed [67:0] W_HI = 68'sd2147483648;
    localparam logic signed [67:0] W_LO = -68'sd2147483648;
    localparam logic signed [63:0] ONE_S64 = 64'sd1073741824;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    state_t state_reg;
    state_t state_next;
    logic [4:0]  cnt_reg;
    logic [2:0]  kidx_reg;
    logic [2:0]  idx_reg;
    logic        sel_reg;
    logic        out_valid_reg;

    logic signed [31:0] vx_reg;
    logic signed [31:0] vy_reg;
    logic signed [31:0] vz_reg;
    logic [63:0]  n_reg;
    logic [31:0]  root_reg;
    logic [35:0]  ang_reg;
    logic         neg_reg;
    logic [30:0]  x_reg;
    logic [31:0]  x2_reg;
    logic [30:0]  t_reg;
    logic [31:0]  prod_reg;
    logic [31:0]  qe_reg;
    logic [30:0]  s1mag_reg;
    logic         s1neg_reg;
    logic         s2neg_reg;
    logic [31:0]  rem1_reg;
    logic [31:0]  rem2_reg;
    logic [31:0]  nlo1_reg;
    logic [31:0]  nlo2_reg;
    logic [31:0]  quo1_reg;
    logic [31:0]  quo2_reg;
    logic signed [31:0] a_reg;
    logic signed [31:0] c_reg;
    logic signed [34:0] p_reg [3];
    logic signed [32:0] w_reg [3];
    logic [62:0]  sq_reg [3];
    logic signed [32:0] b_reg [3];
    s3em_pkg::res_t res_reg;
    s3em_pkg::res_t out_reg;

    logic signed [33:0] ma;
    logic signed [33:0] mb;
    logic signed [67:0] mp;
    logic signed [67:0] mshr28;
    logic signed [67:0] mshr31;
    logic [31:0]  cand;
    logic [35:0]  red_a1;
    logic [35:0]  red_a2;
    logic         fold_neg;
    logic [35:0]  fold_a;
    logic [35:0]  fold_b;
    logic [39:0]  qd;
    logic [39:0]  qrem;
    logic [31:0]  qfix;
    logic [30:0]  sraw;
    logic [30:0]  scap;
    logic [32:0]  sh1;
    logic [32:0]  sh2;
    logic         ge1;
    logic         ge2;
    logic [31:0]  rn1;
    logic [31:0]  rn2;
    logic [31:0]  qn1;
    logic [31:0]  qn2;
    logic signed [31:0] coef;
    logic signed [31:0] vsel;
    logic signed [32:0] wa;
    logic signed [32:0] wb;
    logic signed [63:0] small_s [3];
    logic signed [63:0] pe [3];
    logic signed [63:0] be [3];
    logic [63:0]  dsum [3];
    logic signed [63:0] diag [3];
    logic         out_load;
    logic         is_small;

    // ------------------------------------------------------------------
    // Shared multiplier and its operand selection.
    // ------------------------------------------------------------------
    assign cand = root_reg | (32'd1 << cnt_reg);

    always_comb
    begin
        unique case (idx_reg)
            3'd0, 3'd3: vsel = vx_reg;
            3'd1, 3'd4: vsel = vy_reg;
            default:    vsel = vz_reg;
        endcase
        coef = (idx_reg < 3'd3) ? a_reg : c_reg;
        unique case (idx_reg)
            3'd0:    begin wa = w_reg[0]; wb = w_reg[0]; end
            3'd1:    begin wa = w_reg[1]; wb = w_reg[1]; end
            3'd2:    begin wa = w_reg[2]; wb = w_reg[2]; end
            3'd3:    begin wa = w_reg[0]; wb = w_reg[1]; end
            3'd4:    begin wa = w_reg[0]; wb = w_reg[2]; end
            default: begin wa = w_reg[1]; wb = w_reg[2]; end
        endcase
    end

    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (state_reg)
            ST_SQRT:
            begin
                ma = $signed({2'b00, cand});
                mb = $signed({2'b00, cand});
            end
            ST_SX2:
            begin
                ma = $signed({3'b000, x_reg});
                mb = $signed({3'b000, x_reg});
            end
            ST_SMUL:
            begin
                ma = $signed({2'b00, x2_reg});
                mb = $signed({3'b000, t_reg});
            end
            ST_SREC:
            begin
                ma = $signed({2'b00, prod_reg});
                mb = $signed({4'b0000, s3em_pkg::sine_recip(kidx_reg)});
            end
            ST_SFIN:
            begin
                ma = $signed({3'b000, x_reg});
                mb = $signed({3'b000, t_reg});
            end
            ST_PROD:
            begin
                ma = 34'(coef);
                mb = 34'(vsel);
            end
            ST_BPRD:
            begin
                ma = 34'(wa);
                mb = 34'(wb);
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign mp     = ma * mb;
    assign mshr28 = mp >>> 28;
    assign mshr31 = mp >>> 31;

    // ------------------------------------------------------------------
    // Sine: range reduction, fold to the first quadrant, Horner steps.
    // ------------------------------------------------------------------
    always_comb
    begin
        red_a1   = (ang_reg >= s3em_pkg::TWO_PI_Q32) ? ang_reg - s3em_pkg::TWO_PI_Q32 : ang_reg;
        red_a2   = (red_a1 >= s3em_pkg::TWO_PI_Q32) ? red_a1 - s3em_pkg::TWO_PI_Q32 : red_a1;
        fold_neg = ang_reg >= s3em_pkg::PI_Q32;
        fold_a   = fold_neg ? ang_reg - s3em_pkg::PI_Q32 : ang_reg;
        fold_b   = (fold_a > s3em_pkg::HALF_PI_Q32) ? s3em_pkg::PI_Q32 - fold_a : fold_a;
    end

    // The reciprocal estimate is at most one below the true quotient.
    assign qd   = 40'(qe_reg) * 40'(s3em_pkg::sine_div(kidx_reg));
    assign qrem = 40'(prod_reg) - qd;
    assign qfix = qe_reg + 32'(qrem >= 40'(s3em_pkg::sine_div(kidx_reg)));

    assign sraw = mp[60:30];
    assign scap = (sraw > s3em_pkg::ONE_Q30) ? s3em_pkg::ONE_Q30 : sraw;

    // ------------------------------------------------------------------
    // Two restoring dividers sharing the magnitude as divisor.
    // ------------------------------------------------------------------
    always_comb
    begin
        sh1 = {rem1_reg, nlo1_reg[cnt_reg]};
        sh2 = {rem2_reg, nlo2_reg[cnt_reg]};
        ge1 = sh1 >= {1'b0, root_reg};
        ge2 = sh2 >= {1'b0, root_reg};
        rn1 = ge1 ? 32'(sh1 - {1'b0, root_reg}) : sh1[31:0];
        rn2 = ge2 ? 32'(sh2 - {1'b0, root_reg}) : sh2[31:0];
        qn1 = {quo1_reg[30:0], ge1};
        qn2 = {quo2_reg[30:0], ge2};
    end

    // ------------------------------------------------------------------
    // Matrix assembly for both paths.
    // ------------------------------------------------------------------
    always_comb
    begin
        is_small   = (root_reg == '0) || (root_reg < 32'(thresh));
        small_s[0] = 64'(vx_reg) <<< 2;
        small_s[1] = 64'(vy_reg) <<< 2;
        small_s[2] = 64'(vz_reg) <<< 2;
        for (int i = 0; i < 3; i++)
        begin
            small_s[i] = $signed(64'(sat32(small_s[i])) );
            small_s[i] = $signed({{32{small_s[i][31]}}, small_s[i][31:0]});
            pe[i]      = 64'(p_reg[i]);
            be[i]      = 64'(b_reg[i]);
        end
        dsum[0] = 64'(sq_reg[1]) + 64'(sq_reg[2]);
        dsum[1] = 64'(sq_reg[0]) + 64'(sq_reg[2]);
        dsum[2] = 64'(sq_reg[0]) + 64'(sq_reg[1]);
        for (int i = 0; i < 3; i++)
        begin
            diag[i] = ONE_S64 - $signed({31'b0, dsum[i][63:31]});
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || res_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (q_valid) state_next = ST_SQRT;
            ST_SQRT:  if (cnt_reg == '0) state_next = ST_CLASS;
            ST_CLASS: state_next = is_small ? ST_DONE : ST_SRED1;
            ST_SRED1: state_next = ST_SRED2;
            ST_SRED2: state_next = ST_SX2;
            ST_SX2:   state_next = ST_SMUL;
            ST_SMUL:  state_next = ST_SREC;
            ST_SREC:  state_next = ST_SCOR;
            ST_SCOR:  state_next = (kidx_reg == '0) ? ST_SFIN : ST_SMUL;
            ST_SFIN:  state_next = sel_reg ? ST_DIV : ST_SRED1;
            ST_DIV:   if (cnt_reg == '0) state_next = ST_PROD;
            ST_PROD:  if (idx_reg == 3'd5) state_next = ST_BPRD;
            ST_BPRD:  if (idx_reg == 3'd5) state_next = ST_SUM;
            ST_SUM:   state_next = ST_DONE;
            ST_DONE:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            kidx_reg      <= '0;
            idx_reg       <= '0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:  cnt_reg <= 5'd31;
                ST_SQRT:  cnt_reg <= cnt_reg - 1'b1;
                ST_CLASS: sel_reg <= 1'b0;
                ST_SX2:   kidx_reg <= s3em_pkg::SINE_FIRST;
                ST_SCOR:  kidx_reg <= kidx_reg - 1'b1;
                ST_SFIN:
                begin
                    sel_reg <= 1'b1;
                    cnt_reg <= 5'd31;
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    idx_reg <= '0;
                end
                ST_PROD:  idx_reg <= (idx_reg == 3'd5) ? 3'd0 : idx_reg + 1'b1;
                ST_BPRD:  idx_reg <= idx_reg + 1'b1;
                default:  ;
            endcase
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= res_reg;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                vx_reg   <= q_item.vx;
                vy_reg   <= q_item.vy;
                vz_reg   <= q_item.vz;
                n_reg    <= q_item.sumsq;
                root_reg <= '0;
            end
            ST_SQRT:
            begin
                if (mp[63:0] <= n_reg)
                begin
                    root_reg <= cand;
                end
            end
            ST_CLASS:
            begin
                ang_reg <= {root_reg, 4'b0000};
                res_reg.small_angle <= 1'b1;
                res_reg.r[0] <= 32'(ONE_S64);
                res_reg.r[1] <= sat32(-small_s[2]);
                res_reg.r[2] <= small_s[1][31:0];
                res_reg.r[3] <= small_s[2][31:0];
                res_reg.r[4] <= 32'(ONE_S64);
                res_reg.r[5] <= sat32(-small_s[0]);
                res_reg.r[6] <= sat32(-small_s[1]);
                res_reg.r[7] <= small_s[0][31:0];
                res_reg.r[8] <= 32'(ONE_S64);
            end
            ST_SRED1: ang_reg <= red_a2;
            ST_SRED2:
            begin
                neg_reg <= fold_neg;
                x_reg   <= fold_b[32:2];
            end
            ST_SX2:
            begin
                x2_reg <= mp[61:30];
                t_reg  <= s3em_pkg::ONE_Q30;
            end
            ST_SMUL:  prod_reg <= mp[61:30];
            ST_SREC:  qe_reg <= mp[63:32];
            ST_SCOR:  t_reg <= s3em_pkg::ONE_Q30 - qfix[30:0];
            ST_SFIN:
            begin
                if (!sel_reg)
                begin
                    s1mag_reg <= scap;
                    s1neg_reg <= neg_reg;
                    ang_reg   <= {1'b0, root_reg, 3'b000};
                end
                else
                begin
                    // Dividends are |sin| << 28 and |sin| << 29; the upper part
                    // is already below the divisor since each quotient is under 2^32.
                    s2neg_reg <= neg_reg;
                    rem1_reg  <= 32'(s1mag_reg[30:4]);
                    nlo1_reg  <= {s1mag_reg[3:0], 28'b0};
                    rem2_reg  <= 32'(scap[30:3]);
                    nlo2_reg  <= {scap[2:0], 29'b0};
                    quo1_reg  <= '0;
                    quo2_reg  <= '0;
                end
            end
            ST_DIV:
            begin
                rem1_reg <= rn1;
                rem2_reg <= rn2;
                quo1_reg <= qn1;
                quo2_reg <= qn2;
                a_reg    <= s1neg_reg ? -$signed(qn1) : $signed(qn1);
                c_reg    <= s2neg_reg ? -$signed(qn2) : $signed(qn2);
            end
            ST_PROD:
            begin
                unique case (idx_reg)
                    3'd0:    p_reg[0] <= mshr28[34:0];
                    3'd1:    p_reg[1] <= mshr28[34:0];
                    3'd2:    p_reg[2] <= mshr28[34:0];
                    3'd3:    w_reg[0] <= (mshr28 > W_HI) ? W_HI[32:0] :
                                         (mshr28 < W_LO) ? W_LO[32:0] : mshr28[32:0];
                    3'd4:    w_reg[1] <= (mshr28 > W_HI) ? W_HI[32:0] :
                                         (mshr28 < W_LO) ? W_LO[32:0] : mshr28[32:0];
                    default: w_reg[2] <= (mshr28 > W_HI) ? W_HI[32:0] :
                                         (mshr28 < W_LO) ? W_LO[32:0] : mshr28[32:0];
                endcase
            end
            ST_BPRD:
            begin
                unique case (idx_reg)
                    3'd0:    sq_reg[0] <= mp[62:0];
                    3'd1:    sq_reg[1] <= mp[62:0];
                    3'd2:    sq_reg[2] <= mp[62:0];
                    3'd3:    b_reg[0] <= mshr31[32:0];
                    3'd4:    b_reg[1] <= mshr31[32:0];
                    default: b_reg[2] <= mshr31[32:0];
                endcase
            end
            ST_SUM:
            begin
                res_reg.small_angle <= 1'b0;
                res_reg.r[0] <= sat32(diag[0]);
                res_reg.r[1] <= sat32(be[0] - pe[2]);
                res_reg.r[2] <= sat32(pe[1] + be[1]);
                res_reg.r[3] <= sat32(pe[2] + be[0]);
                res_reg.r[4] <= sat32(diag[1]);
                res_reg.r[5] <= sat32(be[2] - pe[0]);
                res_reg.r[6] <= sat32(be[1] - pe[1]);
                res_reg.r[7] <= sat32(pe[0] + be[2]);
                res_reg.r[8] <= sat32(diag[2]);
            end
            default: ;
        endcase
    end

    assign res_valid = out_valid_reg;
    assign res_out   = out_reg;

    `S3EM_ASSERT_NEXT(a_sqrt_exit, clk, rst_n, (state_reg == ST_SQRT) && (cnt_reg == '0), state_reg == ST_CLASS)
    `S3EM_ASSERT_IMPL(a_div_rem, clk, rst_n, state_reg == ST_DIV, (rem1_reg < root_reg) && (rem2_reg < root_reg))
    `S3EM_ASSERT_IMPL(a_sine_mag, clk, rst_n, state_reg == ST_SRED1, root_reg != '0)
    `S3EM_ASSERT_IMPL(a_horner_t, clk, rst_n, state_reg == ST_SMUL, t_reg <= s3em_pkg::ONE_Q30)
    `S3EM_ASSERT_IMPL(a_small_diag, clk, rst_n, out_valid_reg && out_reg.small_angle, (out_reg.r[0] == 32'h4000_0000) && (out_reg.r[8] == 32'h4000_0000))

endmodule

@@ src/so3_exponential_map.sv @@
// Path: an accepted input item passes the front stage and the queue; the core then runs
// the root and, on the full path only, two sines, the divide, products and sums.
// The core takes a new item only once it has put out the last, as its single shared
// multiplier serves the sequenced root, sine and divide.
// Reset: asynchronous, active low; clears control state and sets the threshold.
// ----------------------------------------------------------------------------
// SO(3) exponential map
// Rotation vector in Q3.28 to rotation matrix in Q1.30 by Rodrigues' formula.
// ----------------------------------------------------------------------------
module so3_exponential_map #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // rot_x, rot_y, rot_z from bit 0 up
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [287:0] m_tdata,   // r00, r01, r02, r10, r11, r12, r20, r21, r22
    output logic         m_tuser,   // small_angle
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [s3em_pkg::THRESH_W-1:0] thresh_reg;
    logic              push_valid;
    logic              push_ready;
    s3em_pkg::q_item_t push_item;
    logic              pop_valid;
    logic              pop;
    s3em_pkg::q_item_t pop_item;
    s3em_pkg::res_t    res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == s3em_pkg::REG_SMALL_THRESH) ? 32'(thresh_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= s3em_pkg::THRESH_RESET;
        end
        else if (psel && penable && pwrite && pready &&
                 (paddr[2] == s3em_pkg::REG_SMALL_THRESH))
        begin
            thresh_reg <= pwdata[s3em_pkg::THRESH_W-1:0];
        end
    end

    s3em_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    s3em_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_item   (pop_item)
    );

    s3em_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .thresh    (thresh_reg),
        .q_valid   (pop_valid),
        .q_pop     (pop),
        .q_item    (pop_item),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_out   (res)
    );

    assign m_tdata = res.r;
    assign m_tuser = res.small_angle;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Rotation-vector exponential map testbench
// Drives rotation vectors over the input stream, predicts each rotation matrix
// with a bit-exact fixed-point model, and compares every result item in order.
// The small-angle threshold is reprogrammed between phases over APB.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_THRESH = 3'd0;
    localparam logic [2:0] ADDR_UNUSED = 3'd4;
    localparam longint Q30 = 64'sd1073741824;
    localparam longint PI32 = 64'h3_243F_6A89;
    localparam longint HPI32 = 64'h1_921F_B544;
    localparam longint TPI32 = 64'h6_487E_D511;
    localparam int WATCHDOG = 20000;
    localparam int DRAIN = 400;

    typedef struct {
        logic [31:0] r[9];
        logic        small_angle;
    } matrix_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        bit          known;
        logic [31:0] r00;
        logic        small_angle;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [287:0] m_tdata;
    logic         m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    so3_exponential_map i_dut (.*);

    logic [28:0] threshold;
    matrix_t     pending_matrices[$];
    int          mismatches;
    int          idle_cycles;
    bit          timed_out;
    bit          rx_idle_on;
    bit          long_hold;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Floor shift that also works for negative values.
    function automatic longint asr(input longint v, input int k);
        return v >>> k;
    endfunction

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint sine_fixed(input longint unsigned ang);
        bit                  neg;
        longint unsigned     x;
        longint unsigned     x2;
        longint unsigned     t;
        longint unsigned     s;
        neg = 1'b0;
        if (ang >= TPI32) ang -= TPI32;
        if (ang >= TPI32) ang -= TPI32;
        if (ang >= PI32)
        begin
            ang -= PI32;
            neg = 1'b1;
        end
        if (ang > HPI32) ang = PI32 - ang;
        x = ang >> 2;
        x2 = (x * x) >> 30;
        t = Q30;
        for (int k = 7; k >= 1; k--)
            t = Q30 - ((x2 * t) >> 30) / ((2 * k) * (2 * k + 1));
        s = (x * t) >> 30;
        if (s > Q30) s = Q30;
        return neg ? -longint'(s) : longint'(s);
    endfunction

    function automatic longint clamp_w(input longint w);
        if (w > 64'sd2147483648) return 64'sd2147483648;
        if (w < -64'sd2147483648) return -64'sd2147483648;
        return w;
    endfunction

    function automatic matrix_t rodrigues(input logic [31:0] rx, input logic [31:0] ry,
                                          input logic [31:0] rz);
        matrix_t         m;
        longint          vx, vy, vz, a, c, px, py, pz, wx, wy, wz, bxy, bxz, byz;
        longint unsigned sq, mag, cand, qx, qy, qz;
        longint          e[9];
        vx = longint'(signed'(rx));
        vy = longint'(signed'(ry));
        vz = longint'(signed'(rz));
        sq = longint'(vx * vx) + longint'(vy * vy) + longint'(vz * vz);
        mag = 0;
        for (int b = 31; b >= 0; b--)
        begin
            cand = mag | (64'd1 << b);
            if (cand * cand <= sq) mag = cand;
        end
        m.small_angle = (mag == 0 || mag < threshold);
        if (m.small_angle)
        begin
            px = sat32(vx * 4);
            py = sat32(vy * 4);
            pz = sat32(vz * 4);
            e = '{Q30, -pz, py, pz, Q30, -px, -py, px, Q30};
        end
        else
        begin
            a = (sine_fixed(mag << 4) * 64'sd268435456) / longint'(mag);
            c = (sine_fixed(mag << 3) * 64'sd536870912) / longint'(mag);
            px = asr(a * vx, 28);
            py = asr(a * vy, 28);
            pz = asr(a * vz, 28);
            wx = clamp_w(asr(c * vx, 28));
            wy = clamp_w(asr(c * vy, 28));
            wz = clamp_w(asr(c * vz, 28));
            qx = wx * wx;
            qy = wy * wy;
            qz = wz * wz;
            bxy = asr(wx * wy, 31);
            bxz = asr(wx * wz, 31);
            byz = asr(wy * wz, 31);
            e[0] = Q30 - longint'((qy + qz) >> 31);
            e[1] = -pz + bxy;
            e[2] = py + bxz;
            e[3] = pz + bxy;
            e[4] = Q30 - longint'((qx + qz) >> 31);
            e[5] = -px + byz;
            e[6] = -py + bxz;
            e[7] = px + byz;
            e[8] = Q30 - longint'((qx + qy) >> 31);
        end
        for (int i = 0; i < 9; i++)
            m.r[i] = 32'(sat32(e[i]));
        return m;
    endfunction

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_THRESH)
            threshold = value[28:0];
    endtask

    task automatic send_vector(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input bit gaps);
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {z, y, x};
        pending_matrices.insert(pending_matrices.size(), rodrigues(x, y, z));
        do @(posedge clk); while (!s_tready);
    endtask

    // Drop valid at the edge that took the last item, then wait for the results.
    task automatic settle;
        s_tvalid <= 1'b0;
        while (pending_matrices.size() != 0 && !timed_out) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_component(input int mode);
        case (mode)
            0: return $urandom();
            1: return 32'(signed'($urandom_range(0, 1 << 29)) - (1 << 28));
            2: return 32'(signed'($urandom_range(0, 2000)) - 1000);
            default: return 32'(signed'($urandom_range(0, 1 << 31)) - (1 << 30));
        endcase
    endfunction

    task automatic random_phase(input int count, input bit gaps);
        int mode;
        for (int n = 0; n < count; n++)
        begin
            mode = $urandom_range(0, 3);
            send_vector(rand_component(mode), rand_component(mode),
                        rand_component(mode), gaps);
        end
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        matrix_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_matrices.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %h", m_tdata);
            end
            else
            begin
                want = pending_matrices.pop_front();
                for (int i = 0; i < 9; i++)
                    if (m_tdata[32*i +: 32] !== want.r[i])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("entry %0d: expected %h, got %h", i, want.r[i],
                                     m_tdata[32*i +: 32]);
                    end
                if (m_tuser !== want.small_angle)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("small_angle: expected %b, got %b", want.small_angle,
                                 m_tuser);
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when requested.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (3000) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG && !timed_out)
            timed_out = 1'b1;
    end

    row_t directed[$];

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        threshold = s3em_pkg::THRESH_RESET;
        rx_idle_on = 1'b1;
        long_hold = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Zero vector gives identity; it and two short vectors pin r00 and the small-angle flag.
        directed = '{
            '{32'd0, 32'd0, 32'd0, 1'b1, 32'h4000_0000, 1'b1},
            '{32'd100, 32'd0, 32'd0, 1'b1, 32'h4000_0000, 1'b1},
            '{32'd0, 32'hFFFF_FF9C, 32'd0, 1'b1, 32'h4000_0000, 1'b1},
            '{32'd268, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0},
            '{32'h1000_0000, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0},
            '{32'd0, 32'h3243_F6A8, 32'd0, 1'b0, 32'd0, 1'b0},
            '{32'd0, 32'd0, 32'h6487_ED51, 1'b0, 32'd0, 1'b0},
            '{32'h7FFF_FFFF, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0},
            '{32'h8000_0000, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'd0, 1'b0},
            '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'd0, 1'b0},
            '{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0},
            '{32'h0800_0000, 32'hF800_0000, 32'h0400_0000, 1'b0, 32'd0, 1'b0}
        };
        foreach (directed[i])
        begin
            send_vector(directed[i].x, directed[i].y, directed[i].z, 1'b0);
            if (directed[i].known)
            begin
                pending_matrices[pending_matrices.size() - 1].r[0] = directed[i].r00;
                pending_matrices[pending_matrices.size() - 1].small_angle =
                    directed[i].small_angle;
            end
        end
        settle();

        // Unknown address is ignored; high bits of the value are dropped.
        apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
        apb_write(ADDR_THRESH, 32'hE000_0000);
        send_vector(32'd0, 32'd0, 32'd0, 1'b0);
        send_vector(32'd1, 32'd0, 32'd0, 1'b0);
        settle();

        apb_write(ADDR_THRESH, 32'h1000_0000);
        random_phase(300, 1'b1);
        long_hold = 1'b1;
        random_phase(40, 1'b0);
        settle();

        apb_write(ADDR_THRESH, 32'h1FFF_FFFF);
        random_phase(150, 1'b1);
        settle();

        apb_write(ADDR_THRESH, 32'd268);
        random_phase(500, 1'b1);
        settle();

        apb_write(ADDR_THRESH, 32'h0000_1000);
        rx_idle_on = 1'b0;
        random_phase(340, 1'b0);
        settle();

        if (!timed_out && mismatches == 0 && pending_matrices.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial
    begin
        wait (timed_out);
        $display("testbench: errors");
        $finish;
    end
endmodule
